// ----- hw/rtl/sha256_hash_engine_defines.svh -----
// Assertion macros used by the SHA-256 hash engine module.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, constants and the round-constant function of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic        load_word;
    logic [31:0] word;
    logic        init_vars;
    logic        do_round;
    logic [5:0]  round;
    logic        add_hash;
    logic        reset_hash;
  } sha_ctl_t;

  localparam logic [31:0] PAD_WORD = 32'h80000000;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/sha_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Holds the hash, working variables and rolling schedule window, and runs one
// compression round per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
module sha_round (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::sha_ctl_t ctl,
  input  logic [2:0]       read_index,
  output logic [31:0]      read_word
);

  logic [31:0] hash [8];
  logic [31:0] vars [8];
  logic [31:0] win [16];
  logic [3:0]  load_ptr;
  logic [3:0]  slot, s2, s7, s15;
  logic [31:0] m2, m7, m15, s0, s1, w, t1, t2, e, a;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Schedule word and round sums.
  always_comb begin
    slot = ctl.round[3:0];
    s2   = slot - 4'd2;
    s7   = slot - 4'd7;
    s15  = slot - 4'd15;
    m2   = win[s2];
    m7   = win[s7];
    m15  = win[s15];
    s1   = rotr(m2, 17) ^ rotr(m2, 19) ^ (m2 >> 10);
    s0   = rotr(m15, 7) ^ rotr(m15, 18) ^ (m15 >> 3);
    w    = (ctl.round[5:4] != 2'd0) ? (s1 + m7 + s0 + win[slot]) : win[slot];
    e    = vars[4];
    a    = vars[0];
    t1   = vars[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & vars[5]) ^ (~e & vars[6])) + sha_pkg::round_k(ctl.round) + w;
    t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & vars[1]) ^ (a & vars[2]) ^ (vars[1] & vars[2]));
  end

  // Word load pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
    end else if (ctl.load_word) begin
      load_ptr <= load_ptr + 4'd1;
    end
  end

  // Schedule window.
  always_ff @(posedge clk) begin
    if (ctl.load_word) begin
      win[load_ptr] <= ctl.word;
    end else if (ctl.do_round) begin
      win[slot] <= w;
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (ctl.init_vars) begin
      for (int i = 0; i < 8; i++) vars[i] <= hash[i];
    end else if (ctl.do_round) begin
      vars[7] <= vars[6]; vars[6] <= vars[5]; vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2]; vars[2] <= vars[1]; vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  // Hash state.
  always_ff @(posedge clk) begin
    if (rst || ctl.reset_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INIT_HASH[255 - 32*i -: 32];
    end else if (ctl.add_hash) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
    end
  end

  assign read_word = hash[read_index];

endmodule

// ----- hw/rtl/sha256_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streams 32-bit message words, pads the message and returns the digest.
// ----------------------------------------------------------------------------
// Usage: raise start with a beat on in_item while busy is low. A beat that
// is not the last holds four bytes; the last beat (end_of_message) holds
// 0 to 4 bytes, first byte in bits 31..24. The engine pads the message and
// appends the 64-bit bit length itself.
// An ordinary beat that completes a 16-word block starts a compression:
// one round per cycle in the shared round unit, then the hash update.
// The last beat is followed by the padding words, one or two blocks
// compressed and the emission of the digest.
// Results: eight digest beats on out_item, one per cycle, marked by
// out_valid; the receiver cannot stall them. After the digest the hash
// returns to its initial value for the next message.
// Reset (rst, synchronous) clears the sequencer and loads the initial hash.
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sha_pkg::sha_in_t  in_item,
  output logic              busy,
  output logic              out_valid,
  output sha_pkg::sha_out_t out_item
);

  sha_pkg::sha_state_t state, state_next;
  sha_pkg::sha_ctl_t   ctl;
  logic [3:0]  count, count_next;
  logic [6:0]  round_count, round_count_next;
  logic [63:0] message_bits, message_bits_next;
  logic        padding, padding_next;
  logic [3:0]  pad_step, pad_step_next;
  logic [2:0]  emit_idx, emit_idx_next;
  logic [31:0] read_word;
  logic        accept;
  logic [2:0]  nb;
  logic [31:0] keep, first_word;

  assign accept = start && !busy;
  assign busy   = (state != sha_pkg::ST_IDLE);

  // Last-word masking and pad byte.
  always_comb begin
    nb = (in_item.valid_bytes > 3'd4) ? 3'd4 : in_item.valid_bytes;
    case (nb)
      3'd0:    begin keep = 32'h0;        first_word = sha_pkg::PAD_WORD; end
      3'd1:    begin keep = 32'hff000000; first_word = 32'h00800000; end
      3'd2:    begin keep = 32'hffff0000; first_word = 32'h00008000; end
      3'd3:    begin keep = 32'hffffff00; first_word = 32'h00000080; end
      default: begin keep = 32'hffffffff; first_word = 32'h0; end
    endcase
    first_word = first_word | (in_item.message_word & keep);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      count <= '0; round_count <= '0; message_bits <= '0;
      padding <= 1'b0; pad_step <= '0; emit_idx <= '0;
    end else begin
      state <= state_next; count <= count_next; round_count <= round_count_next;
      message_bits <= message_bits_next; padding <= padding_next;
      pad_step <= pad_step_next; emit_idx <= emit_idx_next;
    end
  end

  // Sequencer. pad_step: 0 pad word after full last word, 1 zero fill,
  // 2 high length, 3 low length, 4 length written.
  always_comb begin
    state_next = state; count_next = count; round_count_next = round_count;
    message_bits_next = message_bits; padding_next = padding;
    pad_step_next = pad_step; emit_idx_next = emit_idx;
    ctl = '0;
    ctl.round = round_count[5:0];
    out_valid = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.load_word = 1'b1;
          count_next = count + 4'd1;
          if (!in_item.end_of_message) begin
            ctl.word = in_item.message_word;
            message_bits_next = message_bits + 64'd32;
            if (count == 4'd15) begin
              state_next = sha_pkg::ST_ROUND; ctl.init_vars = 1'b1;
            end
          end else begin
            message_bits_next = message_bits + {58'd0, nb, 3'd0};
            padding_next = 1'b1;
            ctl.word = (nb == 3'd4) ? in_item.message_word : first_word;
            pad_step_next = (nb == 3'd4) ? 4'd0 : 4'd1;
            if (count == 4'd15) begin
              state_next = sha_pkg::ST_ROUND; ctl.init_vars = 1'b1;
            end else begin
              state_next = sha_pkg::ST_PAD;
            end
          end
        end
      end
      sha_pkg::ST_PAD: begin
        ctl.load_word = 1'b1;
        count_next = count + 4'd1;
        case (pad_step)
          4'd0: begin ctl.word = sha_pkg::PAD_WORD; pad_step_next = 4'd1; end
          4'd1: begin
            ctl.word = '0;
            if (count == 4'd13) pad_step_next = 4'd2;
          end
          4'd2: begin ctl.word = message_bits[63:32]; pad_step_next = 4'd3; end
          default: begin ctl.word = message_bits[31:0]; pad_step_next = 4'd4; end
        endcase
        // Zero fill that reaches word 14 writes the high length word there instead.
        if (pad_step == 4'd1 && count == 4'd14) begin
          ctl.word = message_bits[63:32]; pad_step_next = 4'd3;
        end
        if (count == 4'd15) begin
          state_next = sha_pkg::ST_ROUND; ctl.init_vars = 1'b1;
        end
      end
      sha_pkg::ST_ROUND: begin
        ctl.do_round = 1'b1;
        round_count_next = round_count + 7'd1;
        if (round_count == 7'd63) state_next = sha_pkg::ST_UPDATE;
      end
      sha_pkg::ST_UPDATE: begin
        ctl.add_hash = 1'b1;
        round_count_next = '0;
        if (!padding) state_next = sha_pkg::ST_IDLE;
        else if (pad_step == 4'd4) state_next = sha_pkg::ST_EMIT;
        else state_next = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        emit_idx_next = emit_idx + 3'd1;
        if (emit_idx == 3'd7) begin
          state_next = sha_pkg::ST_IDLE;
          ctl.reset_hash = 1'b1;
          padding_next = 1'b0;
          message_bits_next = '0;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  sha_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .read_index(emit_idx), .read_word(read_word)
  );

  assign out_item.digest_word  = read_word;
  assign out_item.digest_index = emit_idx;
  assign out_item.digest_last  = (emit_idx == 3'd7);

  // Checks on the sequencer.
  `SHA_ASSERT_IMPL(a_emit_busy, clk, rst, out_valid, busy, "digest beat while idle")
  `SHA_ASSERT_NEXT(a_round_done, clk, rst, state == sha_pkg::ST_ROUND && round_count == 7'd63,
    state == sha_pkg::ST_UPDATE, "compression did not end after 64 rounds")
  `SHA_ASSERT_IMPL(a_round_zero, clk, rst, state == sha_pkg::ST_IDLE, round_count == 7'd0,
    "round count not cleared when idle")

endmodule

// ----- tb/sha256_hash_engine_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches accepted message beats and digest beats of the hash engine, keeps
// its own running SHA-256 state and compares each digest beat in order.
// ----------------------------------------------------------------------------
module sha256_hash_engine_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  sha_pkg::sha_in_t  in_item,
  input  logic              out_valid,
  input  sha_pkg::sha_out_t out_item,
  output int                fail_count,
  output int                digests_pending
);

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic [31:0]       hash_state [8];
  logic [31:0]       block_words [16];
  logic [63:0]       bit_length;
  int                word_fill;
  sha_pkg::sha_out_t digest_queue [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Full 64-round compression of the buffered block into the hash state.
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic append_word(input logic [31:0] w);
    block_words[word_fill] = w;
    word_fill = (word_fill + 1) % 16;
    if (word_fill == 0) compress();
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
    bit_length = '0;
    word_fill = 0;
  endtask

  // Consume one message beat; the final beat pads and queues the digest.
  task automatic absorb_beat(input sha_pkg::sha_in_t beat);
    int                nbytes;
    logic [31:0]       keep;
    sha_pkg::sha_out_t d;
    nbytes = beat.valid_bytes;
    if (nbytes > 4 || !beat.end_of_message) nbytes = 4;
    if (!beat.end_of_message) begin
      bit_length += 64'd32;
      append_word(beat.message_word);
      return;
    end
    bit_length += 64'(nbytes * 8);
    if (nbytes == 4) begin
      append_word(beat.message_word);
      append_word(sha_pkg::PAD_WORD);
    end else if (nbytes == 0) begin
      append_word(sha_pkg::PAD_WORD);
    end else begin
      keep = 32'hffffffff << (32 - 8 * nbytes);
      append_word((beat.message_word & keep) | (32'h80 << (24 - 8 * nbytes)));
    end
    if (word_fill > 14) append_word('0);
    while (word_fill != 14) append_word('0);
    append_word(bit_length[63:32]);
    append_word(bit_length[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_state[i];
      d.digest_index = 3'(i);
      d.digest_last = (i == 7);
      digest_queue.push_back(d);
    end
    restart_message();
  endtask

  assign digests_pending = digest_queue.size();

  // Sample both channels at the rising edge; compare digest beats in order.
  always @(posedge clk) begin
    sha_pkg::sha_out_t exp_beat;
    if (rst) begin
      fail_count = 0;
      digest_queue.delete();
      restart_message();
    end else begin
      if (out_valid) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected digest beat %h", out_item);
        end else begin
          exp_beat = digest_queue.pop_front();
          if (out_item.digest_word !== exp_beat.digest_word ||
              out_item.digest_index !== exp_beat.digest_index ||
              out_item.digest_last !== exp_beat.digest_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: digest beat expected word %h idx %0d last %0b, got %h %0d %0b",
                       exp_beat.digest_word, exp_beat.digest_index, exp_beat.digest_last,
                       out_item.digest_word, out_item.digest_index, out_item.digest_last);
          end
        end
      end
      if (start && !busy) absorb_beat(in_item);
    end
  end
endmodule

// ----- tb/sha256_hash_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Drives directed and random messages with random gaps into the engine; the
// checker predicts every digest and the top reports the verdict.
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  sha_pkg::sha_in_t  in_item = '0;
  logic              busy, out_valid;
  sha_pkg::sha_out_t out_item;
  int                fail_count, digests_pending;
  int                beats_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sha256_hash_engine uut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .out_valid(out_valid), .out_item(out_item));

  sha256_hash_engine_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .fail_count(fail_count), .digests_pending(digests_pending));

  // Mostly short gaps, now and then a long one, often none.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n < 5) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 80);
    repeat (n) @(negedge clk);
  endtask

  // Present one beat at a falling edge and hold it until the engine takes it.
  // Busy only changes at rising edges, so busy low at a falling edge means
  // the beat is taken at the next rising edge.
  task automatic send_beat(input logic [31:0] w, input logic [2:0] nb, input logic eom);
    in_item.message_word = w;
    in_item.valid_bytes = nb;
    in_item.end_of_message = eom;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
    beats_sent++;
  endtask

  // Message of nwords body beats followed by a final beat.
  task automatic send_message(input int nwords, input logic [2:0] last_nb, input logic rnd_vb);
    for (int i = 0; i < nwords; i++) begin
      send_beat($urandom(), rnd_vb ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
      idle_gap();
    end
    send_beat($urandom(), last_nb, 1'b1);
    idle_gap();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    // Directed: empty message, each final byte count, field extremes, and
    // lengths that force an extra padding block.
    send_beat(32'h0, 3'd0, 1'b1);
    send_beat(32'hffffffff, 3'd4, 1'b1);
    send_beat(32'hffffffff, 3'd1, 1'b1);
    send_beat(32'hffffffff, 3'd2, 1'b1);
    send_beat(32'h61626300, 3'd3, 1'b1);
    send_beat(32'hffffffff, 3'd7, 1'b1);
    send_beat(32'h12345678, 3'd5, 1'b1);
    send_beat(32'h0, 3'd3, 1'b0);
    send_beat(32'hffffffff, 3'd6, 1'b1);
    send_message(13, 3'd4, 1'b0);
    send_message(14, 3'd0, 1'b1);
    // Random: mostly short messages, a few spanning several blocks.
    while (beats_sent < 430) begin
      if ($urandom_range(0, 9) == 0)
        send_message($urandom_range(15, 40), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
      else
        send_message($urandom_range(0, 17), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
    end
    while (digests_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
